// ----- design/cbm_pkg.sv -----
// Shared types, codes and constants of the cartridge bank mapper.
package cbm_pkg;

  // item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_PRG   = 2'd2;
  localparam logic [1:0] MODE_PPU   = 2'd3;

  // result target kinds
  localparam logic [1:0] KIND_PRG  = 2'd0;
  localparam logic [1:0] KIND_CHR  = 2'd1;
  localparam logic [1:0] KIND_NT   = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // mirroring codes
  localparam logic [1:0] MIR_VERT = 2'd0;
  localparam logic [1:0] MIR_HORZ = 2'd1;
  localparam logic [1:0] MIR_SCR0 = 2'd2;
  localparam logic [1:0] MIR_SCR1 = 2'd3;

  // register targets selected by address bits 14..12
  localparam logic [2:0] WR_IRQ_CNT  = 3'd4;
  localparam logic [2:0] WR_IRQ_CTRL = 3'd5;
  localparam logic [2:0] WR_MIRROR   = 3'd6;
  localparam logic [2:0] WR_PRG      = 3'd7;

  // configuration register index
  localparam logic CFG_LAST_PRG = 1'b0;

  localparam logic [7:0]  LAST_PRG_RESET = 8'd7;
  localparam logic [15:0] IRQ_RELOAD     = 16'hFFFF;
  localparam int unsigned IRQ_EN_BIT     = 4;
  localparam logic [13:0] PAL_BASE       = 14'h3F00;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned MAPPED_W = 22;

  // bank state seen by the translation logic
  typedef struct packed {
    logic [7:0]       prg_bank;
    logic [3:0][7:0]  chr_bank;
    logic [1:0]       mirror;
  } bank_view_t;

  // one input item
  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } item_t;

  // irq status out of the register block
  typedef struct packed {
    logic pend;
    logic pend_nxt;
  } irq_stat_t;

endpackage

// ----- design/cbm_regs.sv -----
// Mapper register file and tick-counting IRQ counter.
module cbm_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  cbm_pkg::item_t     item,
  output cbm_pkg::bank_view_t view,
  output cbm_pkg::irq_stat_t irq_stat
);

  logic [7:0]      prg_r, prg_nxt;
  logic [3:0][7:0] chr_r, chr_nxt;
  logic [1:0]      mir_r, mir_nxt;
  logic [15:0]     cnt_r, cnt_nxt;
  logic            ena_r, ena_nxt;
  logic            hi_r, hi_nxt;
  logic            pend_r, pend_nxt;
  logic [2:0]      sel;

  assign sel = item.address[14:12];

  // next state for one item
  always_comb begin
    prg_nxt  = prg_r;
    chr_nxt  = chr_r;
    mir_nxt  = mir_r;
    cnt_nxt  = cnt_r;
    ena_nxt  = ena_r;
    hi_nxt   = hi_r;
    pend_nxt = pend_r;
    if (item.mode == cbm_pkg::MODE_WRITE) begin
      if (item.address[15] && item.address[11]) begin
        case (sel)
          cbm_pkg::WR_IRQ_CNT: begin
            if (hi_r) cnt_nxt = {cnt_r[15:8], item.data};
            else      cnt_nxt = {item.data, cnt_r[7:0]};
            hi_nxt = ~hi_r;
          end
          cbm_pkg::WR_IRQ_CTRL: begin
            hi_nxt   = 1'b0;
            ena_nxt  = item.data[cbm_pkg::IRQ_EN_BIT];
            pend_nxt = 1'b0;
          end
          cbm_pkg::WR_MIRROR: mir_nxt = item.data[1:0];
          cbm_pkg::WR_PRG:    prg_nxt = item.data;
          default:            chr_nxt[sel[1:0]] = item.data;
        endcase
      end
    end else if (item.mode == cbm_pkg::MODE_TICK) begin
      // counter runs only while enabled; underflow fires the irq
      if (ena_r) begin
        if (cnt_r == 16'd0) begin
          ena_nxt  = 1'b0;
          cnt_nxt  = cbm_pkg::IRQ_RELOAD;
          pend_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_r  <= '0;
      chr_r  <= '0;
      mir_r  <= cbm_pkg::MIR_VERT;
      cnt_r  <= '0;
      ena_r  <= 1'b0;
      hi_r   <= 1'b0;
      pend_r <= 1'b0;
    end else if (en) begin
      prg_r  <= prg_nxt;
      chr_r  <= chr_nxt;
      mir_r  <= mir_nxt;
      cnt_r  <= cnt_nxt;
      ena_r  <= ena_nxt;
      hi_r   <= hi_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign view.prg_bank  = prg_r;
  assign view.chr_bank  = chr_r;
  assign view.mirror    = mir_r;
  assign irq_stat.pend     = pend_r;
  assign irq_stat.pend_nxt = pend_nxt;

endmodule

// ----- design/cbm_xlate.sv -----
// PRG and PPU address translation.
module cbm_xlate (
  input  cbm_pkg::item_t      item,
  input  cbm_pkg::bank_view_t view,
  input  logic [7:0]          last_prg,
  output logic [21:0]         mapped,
  output logic                page,
  output logic [1:0]          kind
);

  logic [13:0] pa;

  assign pa = item.address[13:0];

  always_comb begin
    mapped = '0;
    page   = 1'b0;
    kind   = cbm_pkg::KIND_NONE;
    case (item.mode)
      cbm_pkg::MODE_PRG: begin
        // upper window fixed, lower window switchable
        if (item.address[15]) begin
          kind = cbm_pkg::KIND_PRG;
          if (item.address[14]) mapped = {last_prg, item.address[13:0]};
          else                  mapped = {view.prg_bank, item.address[13:0]};
        end
      end
      cbm_pkg::MODE_PPU: begin
        if (!pa[13]) begin
          // pattern tables in four 2 KB slots
          kind   = cbm_pkg::KIND_CHR;
          mapped = {3'd0, view.chr_bank[pa[12:11]], pa[10:0]};
        end else if (pa < cbm_pkg::PAL_BASE) begin
          kind   = cbm_pkg::KIND_NT;
          mapped = {12'd0, pa[9:0]};
          case (view.mirror)
            cbm_pkg::MIR_VERT: page = pa[10];
            cbm_pkg::MIR_HORZ: page = pa[11];
            cbm_pkg::MIR_SCR0: page = 1'b0;
            default:           page = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- design/cartridge_bank_mapper_with_irq_unit.sv -----
// Top level: stream ports, config port, input and result registers.
// Each item passes the input register, then the result register; one item is
// taken every clock unless out_tready stalls a full result register: register
// updates, the IRQ counter step and address translation all complete in the single
// combinational pass between the two registers. irq_line reports the IRQ
// state after the item; translations use the bank state left by all earlier
// items. Configuration register 0 (last_prg_bank, reset 7) sits at byte
// address 0 and should be written only while no item is in flight.
module cartridge_bank_mapper_with_irq_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address[15:0], data[23:16]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // irq_line[0], mapped_address[22:1], nametable_page[23]
  output logic [1:0]  out_tuser,  // target_kind[1:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cbm_pkg::item_t      s1_r;
  logic                s1_vld_r;
  logic                adv;
  cbm_pkg::bank_view_t view;
  cbm_pkg::irq_stat_t  irq_stat;
  logic [7:0]          last_prg_r;
  logic [21:0]         mapped;
  logic                page;
  logic [1:0]          kind;
  logic                out_vld_r;
  logic [23:0]         out_data_r;
  logic [1:0]          out_user_r;

  // pipeline control
  assign adv       = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (in_tready) s1_vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_r.mode    <= in_tuser;
      s1_r.address <= in_tdata[15:0];
      s1_r.data    <= in_tdata[23:16];
    end
  end

  // config register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == cbm_pkg::CFG_LAST_PRG) ? {24'd0, last_prg_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_prg_r <= cbm_pkg::LAST_PRG_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == cbm_pkg::CFG_LAST_PRG) begin
      last_prg_r <= cfg_pwdata[7:0];
    end
  end

  cbm_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .item     (s1_r),
    .view     (view),
    .irq_stat (irq_stat)
  );

  cbm_xlate u_xlate (
    .item     (s1_r),
    .view     (view),
    .last_prg (last_prg_r),
    .mapped   (mapped),
    .page     (page),
    .kind     (kind)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= 1'b1;
    else if (out_tready) out_vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {page, mapped, irq_stat.pend_nxt};
      out_user_r <= kind;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // checks
  a_nt_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == cbm_pkg::KIND_NT |-> out_tdata[22:11] == 12'd0)
    else $error("nametable offset out of page");

  a_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != cbm_pkg::KIND_NT |-> !out_tdata[23])
    else $error("page set on non-nametable result");

  a_irq_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_stat.pend) |-> $past(adv && s1_r.mode == cbm_pkg::MODE_TICK))
    else $error("irq raised without tick");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule
